// ===== src/stp_pkg.sv =====
// shared types and constants of the software timer pool
`default_nettype none
package stp_pkg;

   localparam int TIMER_COUNT_DEFAULT = 8;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 3;
   localparam int LIMIT_W = 32;
   localparam int STEP_W  = 16;
   localparam int MODE_W  = 2;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

   // code seven has no operation behind it
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE = 3'd0,
      FUNC_REMOVE = 3'd1,
      FUNC_START  = 3'd2,
      FUNC_RESET  = 3'd3,
      FUNC_STOP   = 3'd4,
      FUNC_TICK   = 3'd5,
      FUNC_QUERY  = 3'd6,
      FUNC_UNUSED = 3'd7
   } func_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOPPED = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_TIMEOUT = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_RD,
      ST_MOD,
      ST_DONE
   } state_type;

   // memory access strobes from the controller
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage
`default_nettype wire

// ===== src/stp_req_if.sv =====
// request channel of the timer pool
`default_nettype none
interface stp_req_if;
   logic                         valid;
   logic                         ready;
   logic [stp_pkg::FUNC_W-1:0]   func;
   logic [stp_pkg::INDEX_W-1:0]  timer_index;
   logic [stp_pkg::LIMIT_W-1:0]  limit_value;

   modport source (output valid, func, timer_index, limit_value, input ready);
   modport sink (input valid, func, timer_index, limit_value, output ready);
endinterface
`default_nettype wire

// ===== src/stp_rsp_if.sv =====
// response channel of the timer pool
`default_nettype none
interface stp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [stp_pkg::INDEX_W-1:0]  slot;
   logic [stp_pkg::MODE_W-1:0]   mode_out;

   modport source (output valid, ok, slot, mode_out, input ready);
   modport sink (input valid, ok, slot, mode_out, output ready);
endinterface
`default_nettype wire

// ===== src/stp_store.sv =====
// slot memory holding mode, limit and counter, with per-entry written marks
`default_nettype none
module stp_store #(
   parameter int TIMER_COUNT = stp_pkg::TIMER_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEFAULT,
   localparam int IDX_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
   localparam int ENTRY_W    = stp_pkg::MODE_W + 2 * COUNT_WIDTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire stp_pkg::mem_cmd_type cmd,
   input  wire [IDX_W-1:0]           rd_addr,
   input  wire [IDX_W-1:0]           wr_addr,
   input  wire [ENTRY_W-1:0]         wr_data,
   output logic [ENTRY_W-1:0]        rd_data
);

   logic [ENTRY_W-1:0]     mem [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] written_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // never-written entries read as the cleared value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== src/stp_ctrl.sv =====
// sequencer: operation decode, slot scan, tick update and response register
`default_nettype none
module stp_ctrl #(
   parameter int TIMER_COUNT = stp_pkg::TIMER_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEFAULT,
   localparam int IDX_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
   localparam int ENTRY_W    = stp_pkg::MODE_W + 2 * COUNT_WIDTH
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire [stp_pkg::FUNC_W-1:0]      req_func,
   input  wire [stp_pkg::INDEX_W-1:0]     req_timer_index,
   input  wire [stp_pkg::LIMIT_W-1:0]     req_limit_value,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_ok,
   output logic [stp_pkg::INDEX_W-1:0]    rsp_slot,
   output logic [stp_pkg::MODE_W-1:0]     rsp_mode_out,
   input  wire                            csr_write_enable,
   input  wire [stp_pkg::STEP_W-1:0]      csr_write_data,
   output stp_pkg::mem_cmd_type           cmd,
   output logic [IDX_W-1:0]               rd_addr,
   output logic [IDX_W-1:0]               wr_addr,
   output logic [ENTRY_W-1:0]             wr_data,
   input  wire [ENTRY_W-1:0]              rd_data
);

   localparam int CW    = COUNT_WIDTH;
   localparam int SUM_W = ((CW > stp_pkg::STEP_W) ? CW : stp_pkg::STEP_W) + 1;
   localparam logic [CW-1:0]    COUNT_MAX = {CW{1'b1}};
   localparam logic [IDX_W-1:0] LAST      = IDX_W'(TIMER_COUNT - 1);

   stp_pkg::state_type             state_ff, state_in;
   stp_pkg::func_type              func_ff, func_in;
   logic [stp_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic                           idx_valid_ff, idx_valid_in;
   logic [CW-1:0]                  val_ff, val_in;
   logic [IDX_W-1:0]               cnt_ff, cnt_in;
   logic [TIMER_COUNT-1:0]         busy_ff, busy_in;
   logic [stp_pkg::STEP_W-1:0]     step_ff;
   logic                           res_ok_ff, res_ok_in;
   logic [stp_pkg::INDEX_W-1:0]    res_slot_ff, res_slot_in;
   stp_pkg::mode_type              res_mode_ff, res_mode_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_ok_ff;
   logic [stp_pkg::INDEX_W-1:0]    rsp_slot_ff;
   logic [stp_pkg::MODE_W-1:0]     rsp_mode_ff;

   logic                           accept;
   logic                           out_free;
   logic                           req_idx_valid;
   logic [63:0]                    req_val64;
   logic [IDX_W-1:0]               idx_addr;
   stp_pkg::mode_type              rd_mode;
   logic [CW-1:0]                  rd_limit;
   logic [CW-1:0]                  rd_count;
   logic [SUM_W-1:0]               sum_ext;
   logic [CW-1:0]                  stepped;
   logic                           below;
   logic [CW-1:0]                  tick_count;
   logic                           tick_timeout;
   logic                           tick_active;
   logic                           scan_free;

   assign accept        = (state_ff == stp_pkg::ST_IDLE) && req_valid;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_idx_valid = (32'(req_timer_index) < 32'(TIMER_COUNT));
   assign req_val64     = {32'b0, req_limit_value};
   assign idx_addr      = IDX_W'(idx_ff);

   assign rd_mode  = stp_pkg::mode_type'(rd_data[ENTRY_W-1 -: stp_pkg::MODE_W]);
   assign rd_limit = rd_data[2*CW-1 -: CW];
   assign rd_count = rd_data[CW-1:0];

   // saturating step, then the timeout decision
   assign sum_ext      = SUM_W'(rd_count) + SUM_W'(step_ff);
   assign stepped      = (sum_ext >= SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum_ext[CW-1:0];
   assign below        = rd_count < rd_limit;
   assign tick_count   = below ? stepped : rd_count;
   assign tick_timeout = !below || (stepped == rd_limit);
   assign tick_active  = busy_ff[cnt_ff] && (rd_mode != stp_pkg::MODE_STOPPED);
   assign scan_free    = !busy_ff[cnt_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (stp_pkg::func_type'(req_func) == stp_pkg::FUNC_CREATE) begin
                  state_in = stp_pkg::ST_SCAN;
               end else if (stp_pkg::func_type'(req_func) == stp_pkg::FUNC_TICK) begin
                  state_in = stp_pkg::ST_TICK_RD;
               end else if (req_idx_valid) begin
                  state_in = stp_pkg::ST_RD;
               end else begin
                  state_in = stp_pkg::ST_DONE;
               end
            end
         end
         stp_pkg::ST_SCAN: begin
            if (scan_free || cnt_ff == LAST) begin
               state_in = stp_pkg::ST_DONE;
            end
         end
         stp_pkg::ST_TICK_RD: state_in = stp_pkg::ST_TICK_WR;
         stp_pkg::ST_TICK_WR: begin
            if (cnt_ff == LAST) begin
               state_in = idx_valid_ff ? stp_pkg::ST_RD : stp_pkg::ST_DONE;
            end
         end
         stp_pkg::ST_RD:  state_in = stp_pkg::ST_MOD;
         stp_pkg::ST_MOD: state_in = stp_pkg::ST_DONE;
         stp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = stp_pkg::ST_IDLE;
            end
         end
         default: state_in = stp_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory strobes
   always_comb begin
      cmd          = '0;
      rd_addr      = cnt_ff;
      wr_addr      = cnt_ff;
      wr_data      = '0;
      func_in      = func_ff;
      idx_in       = idx_ff;
      idx_valid_in = idx_valid_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      res_mode_in  = res_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         stp_pkg::ST_IDLE: begin
            if (accept) begin
               func_in      = stp_pkg::func_type'(req_func);
               idx_in       = req_timer_index;
               idx_valid_in = req_idx_valid;
               val_in       = req_val64[CW-1:0];
               cnt_in       = '0;
               res_ok_in    = (stp_pkg::func_type'(req_func) == stp_pkg::FUNC_TICK) ||
                              (req_idx_valid &&
                               stp_pkg::func_type'(req_func) != stp_pkg::FUNC_UNUSED);
               res_slot_in  = req_timer_index;
               res_mode_in  = stp_pkg::MODE_STOPPED;
            end
         end
         stp_pkg::ST_SCAN: begin
            if (scan_free) begin
               cmd.wr_en        = 1'b1;
               wr_data          = {stp_pkg::MODE_STOPPED, val_ff, val_ff};
               busy_in[cnt_ff]  = 1'b1;
               res_ok_in        = 1'b1;
               res_slot_in      = stp_pkg::INDEX_W'(cnt_ff);
               res_mode_in      = stp_pkg::MODE_STOPPED;
            end else if (cnt_ff == LAST) begin
               // pool full
               res_ok_in   = 1'b0;
               res_slot_in = '0;
               res_mode_in = stp_pkg::MODE_STOPPED;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         stp_pkg::ST_TICK_RD: begin
            cmd.rd_en = 1'b1;
         end
         stp_pkg::ST_TICK_WR: begin
            // write back slot cnt while reading the next one
            cmd.wr_en = tick_active;
            wr_data   = {(tick_timeout ? stp_pkg::MODE_TIMEOUT : rd_mode), rd_limit, tick_count};
            if (cnt_ff != LAST) begin
               cmd.rd_en = 1'b1;
               rd_addr   = cnt_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         stp_pkg::ST_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx_addr;
         end
         stp_pkg::ST_MOD: begin
            wr_addr     = idx_addr;
            res_mode_in = rd_mode;
            case (func_ff)
               stp_pkg::FUNC_REMOVE: begin
                  cmd.wr_en          = 1'b1;
                  wr_data            = '0;
                  busy_in[idx_addr]  = 1'b0;
                  res_mode_in        = stp_pkg::MODE_STOPPED;
               end
               stp_pkg::FUNC_START: begin
                  cmd.wr_en   = 1'b1;
                  wr_data     = {stp_pkg::MODE_RUNNING, rd_limit, {CW{1'b0}}};
                  res_mode_in = stp_pkg::MODE_RUNNING;
               end
               stp_pkg::FUNC_RESET: begin
                  cmd.wr_en   = 1'b1;
                  wr_data     = {stp_pkg::MODE_RUNNING, val_ff, {CW{1'b0}}};
                  res_mode_in = stp_pkg::MODE_RUNNING;
               end
               stp_pkg::FUNC_STOP: begin
                  cmd.wr_en   = 1'b1;
                  wr_data     = {stp_pkg::MODE_STOPPED, rd_limit, rd_limit};
                  res_mode_in = stp_pkg::MODE_STOPPED;
               end
               default: ;
            endcase
         end
         stp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stp_pkg::ST_IDLE;
         busy_ff      <= '0;
         step_ff      <= stp_pkg::STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      idx_ff       <= idx_in;
      idx_valid_ff <= idx_valid_in;
      val_ff       <= val_in;
      cnt_ff       <= cnt_in;
      res_ok_ff    <= res_ok_in;
      res_slot_ff  <= res_slot_in;
      res_mode_ff  <= res_mode_in;
      if (state_ff == stp_pkg::ST_DONE && out_free) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_mode_ff <= res_mode_ff;
      end
   end

   assign req_ready    = (state_ff == stp_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_mode_out = rsp_mode_ff;

endmodule
`default_nettype wire

// ===== src/software_timer_pool.sv =====
// top level of the software timer pool
//
//  channel  dir  handshake            word contents
//  req      in   valid/ready          func, timer_index, limit_value
//  rsp      out  valid/ready          ok, slot, mode_out
//  csr      in   write enable only    tick_step (16 bits)
//
// remove, start, reset with value, stop, query and code seven on a slot in the
//   pool pass memory read, modify and write back (no write for query and code
//   seven) and response load; an index out of the pool goes straight to the
//   response load
// create scans busy marks one slot a cycle up to the first free slot, or up to
//   the last slot on a full pool
// tick walks all TIMER_COUNT slots through the memory's read and write ports,
//   overlapping the read of slot i+1 with the write back of slot i, then reads
//   the indexed slot as above only when the index is in the pool
// req ready returns in the cycle the response turns valid
// reset is synchronous; busy marks and per-entry written marks clear at once,
//   so the slot memory needs no clearing pass
// a response waiting on rsp does not block the next request; the block holds
//   in its final state only when the response register is still full
`default_nettype none
module software_timer_pool #(
   parameter int TIMER_COUNT = stp_pkg::TIMER_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   stp_req_if.sink                      req,
   stp_rsp_if.source                    rsp,
   input  wire                          csr_write_enable,
   input  wire [stp_pkg::STEP_W-1:0]    csr_write_data
);

   localparam int IDX_W   = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int ENTRY_W = stp_pkg::MODE_W + 2 * COUNT_WIDTH;

   // memory side of the sequencer
   stp_pkg::mem_cmd_type   cmd;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;

   // sequencer: decode, create scan, tick walk and response register
   stp_ctrl #(
      .TIMER_COUNT (TIMER_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req.valid),
      .req_ready        (req.ready),
      .req_func         (req.func),
      .req_timer_index  (req.timer_index),
      .req_limit_value  (req.limit_value),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_ok           (rsp.ok),
      .rsp_slot         (rsp.slot),
      .rsp_mode_out     (rsp.mode_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_data          (rd_data)
   );

   // per-slot mode, limit and counter, one read and one write a cycle
   stp_store #(
      .TIMER_COUNT (TIMER_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
